[src/trp_pkg.sv]
// Package for the task run-time profiler: table size, widths, action and result codes.
// Shared by the controller and the top level. No dependencies.
package trp_pkg;

  localparam int MAX_TASKS = 8;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int IDW = 8;
  localparam int TW = 32;

  localparam logic [TW-1:0] HDR_BASE = TW'(4);
  localparam logic [TW-1:0] ENTRY_LEN = TW'(5);

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_START    = 3'd1,
    ACT_END      = 3'd2,
    ACT_ABORT    = 3'd3,
    ACT_REPORT   = 3'd4
  } act_t;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_REFUSED    = 3'd1,
    KIND_HEADER     = 3'd2,
    KIND_TOTAL      = 3'd3,
    KIND_ENTRY      = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADD,
    ST_TOTAL,
    ST_ENTRY
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDW-1:0]   entry_id;
    logic [TW-1:0]    value;
    logic             last;
  } rslt_t;

  typedef struct packed {
    logic             id_we;
    logic             sum_we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [IDW-1:0]   id_wdata;
    logic [TW-1:0]    sum_wdata;
  } mem_req_t;

endpackage

[src/trp_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module trp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/trp_ctrl.sv]
// Profiler controller: event decode, run timing, table read-modify-write and report walk.
// Depends on trp_pkg; drives the id and sum memories through a mem_req_t.
module trp_ctrl
  import trp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_ready,
  input  logic [2:0]     action,
  input  logic [2:0]     slot,
  input  logic [IDW-1:0] task_id,
  input  logic [TW-1:0]  time_now,
  output logic           rslt_valid,
  input  logic           rslt_ready,
  output rslt_t          rslt,
  output mem_req_t       mreq,
  input  logic [IDW-1:0] id_rdata,
  input  logic [TW-1:0]  sum_rdata
);

  state_t         state, state_next;
  logic [2:0]     act_r;
  logic [2:0]     slot_r;
  logic [IDW-1:0] tid_r;
  logic [TW-1:0]  now_r;
  logic [TW-1:0]  elapsed, elapsed_next;
  logic           do_sum, do_sum_next;
  logic [AW-1:0]  idx, idx_next;
  logic [CW-1:0]  task_count, task_count_next;
  logic [TW-1:0]  run_start_time, run_start_time_next;
  logic           run_open, run_open_next;
  logic [TW-1:0]  total_time, total_time_next;
  logic           entry_last;

  assign entry_last = ((CW'(idx) + CW'(1)) == task_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      task_count     <= '0;
      run_start_time <= '0;
      run_open       <= 1'b0;
      total_time     <= '0;
    end else begin
      state          <= state_next;
      task_count     <= task_count_next;
      run_start_time <= run_start_time_next;
      run_open       <= run_open_next;
      total_time     <= total_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && evt_valid) begin
      act_r  <= action;
      slot_r <= slot;
      tid_r  <= task_id;
      now_r  <= time_now;
    end
    elapsed <= elapsed_next;
    do_sum  <= do_sum_next;
    idx     <= idx_next;
  end

  always_comb begin
    state_next          = state;
    task_count_next     = task_count;
    run_start_time_next = run_start_time;
    run_open_next       = run_open;
    total_time_next     = total_time;
    elapsed_next        = elapsed;
    do_sum_next         = do_sum;
    idx_next            = idx;
    evt_ready           = 1'b0;
    rslt_valid          = 1'b0;
    rslt                = '0;
    mreq                = '0;
    mreq.raddr          = idx;

    unique case (state)
      ST_IDLE: begin
        evt_ready = 1'b1;
        if (evt_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (act_t'(act_r))
          ACT_REGISTER: begin
            rslt_valid = 1'b1;
            rslt.last  = 1'b1;
            if (task_count < CW'(MAX_TASKS)) begin
              rslt.kind      = KIND_REGISTERED;
              rslt.value     = TW'(task_count);
              mreq.id_we     = 1'b1;
              mreq.sum_we    = 1'b1;
              mreq.waddr     = AW'(task_count);
              mreq.id_wdata  = tid_r;
              mreq.sum_wdata = '0;
              if (rslt_ready) begin
                task_count_next = task_count + CW'(1);
              end
            end else begin
              rslt.kind = KIND_REFUSED;
            end
            if (rslt_ready) begin
              state_next = ST_IDLE;
            end
          end
          ACT_START: begin
            run_start_time_next = now_r;
            run_open_next       = 1'b1;
            state_next          = ST_IDLE;
          end
          ACT_END, ACT_ABORT: begin
            if (run_open) begin
              elapsed_next  = now_r - run_start_time;
              do_sum_next   = (act_t'(act_r) == ACT_END) &&
                              (8'(slot_r) < 8'(task_count));
              mreq.raddr    = AW'(slot_r);
              run_open_next = 1'b0;
              state_next    = ST_ADD;
            end else begin
              state_next = ST_IDLE;
            end
          end
          ACT_REPORT: begin
            rslt_valid = 1'b1;
            rslt.kind  = KIND_HEADER;
            rslt.value = HDR_BASE + TW'(task_count) * ENTRY_LEN;
            if (rslt_ready) begin
              state_next = ST_TOTAL;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_ADD: begin
        total_time_next = total_time + elapsed;
        if (do_sum) begin
          mreq.sum_we    = 1'b1;
          mreq.waddr     = AW'(slot_r);
          mreq.sum_wdata = sum_rdata + elapsed;
        end
        state_next = ST_IDLE;
      end

      ST_TOTAL: begin
        rslt_valid = 1'b1;
        rslt.kind  = KIND_TOTAL;
        rslt.value = total_time;
        rslt.last  = (task_count == '0);
        mreq.raddr = '0;
        if (rslt_ready) begin
          total_time_next = '0;
          idx_next        = '0;
          state_next      = (task_count == '0) ? ST_IDLE : ST_ENTRY;
        end
      end

      ST_ENTRY: begin
        rslt_valid    = 1'b1;
        rslt.kind     = KIND_ENTRY;
        rslt.entry_id = id_rdata;
        rslt.value    = sum_rdata;
        rslt.last     = entry_last;
        if (rslt_ready) begin
          mreq.sum_we    = 1'b1;
          mreq.waddr     = idx;
          mreq.sum_wdata = '0;
          mreq.raddr     = AW'(CW'(idx) + CW'(1));
          idx_next       = AW'(CW'(idx) + CW'(1));
          if (entry_last) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/task_runtime_profiler.sv]
// Top level of the task run-time profiler: controller, id and sum memories, result register.
// Depends on trp_pkg, trp_ram and trp_ctrl.
//
//   Channel  Handshake              Payload
//   event    evt_valid, evt_ready   action, slot, task_id, time_now
//   result   res_valid, res_ready   kind, entry_id, value, last
//
// An event is accepted in ST_IDLE and executed in ST_EXEC; ending or aborting an open run
// adds ST_ADD, which adds the run time to the total and, for a run end of a registered
// slot, does the read-modify-write of the slot sum. A report gives a header, the total and
// one entry per task, one result per cycle from the sum memory's read port while the result
// side does not stall. Reset needs no clearing pass: a slot sum is zeroed at registration.
module task_runtime_profiler
  import trp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_ready,
  input  logic [2:0]     action,
  input  logic [2:0]     slot,
  input  logic [IDW-1:0] task_id,
  input  logic [TW-1:0]  time_now,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [2:0]     kind,
  output logic [IDW-1:0] entry_id,
  output logic [TW-1:0]  value,
  output logic           last
);

  logic           rslt_valid;
  logic           rslt_ready;
  rslt_t          rslt;
  mem_req_t       mreq;
  logic [IDW-1:0] id_rdata;
  logic [TW-1:0]  sum_rdata;

  trp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .action     (action),
    .slot       (slot),
    .task_id    (task_id),
    .time_now   (time_now),
    .rslt_valid (rslt_valid),
    .rslt_ready (rslt_ready),
    .rslt       (rslt),
    .mreq       (mreq),
    .id_rdata   (id_rdata),
    .sum_rdata  (sum_rdata)
  );

  trp_ram #(.WIDTH(IDW), .DEPTH(MAX_TASKS)) u_id_ram (
    .clk   (clk),
    .we    (mreq.id_we),
    .waddr (mreq.waddr),
    .wdata (mreq.id_wdata),
    .raddr (mreq.raddr),
    .rdata (id_rdata)
  );

  trp_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_sum_ram (
    .clk   (clk),
    .we    (mreq.sum_we),
    .waddr (mreq.waddr),
    .wdata (mreq.sum_wdata),
    .raddr (mreq.raddr),
    .rdata (sum_rdata)
  );

  assign rslt_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rslt_ready) begin
      res_valid <= rslt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rslt_ready && rslt_valid) begin
      kind     <= rslt.kind;
      entry_id <= rslt.entry_id;
      value    <= rslt.value;
      last     <= rslt.last;
    end
  end

endmodule
